// File: hdl/owm_pkg.sv
// ---------------------------------------------------------------------------
// owm_pkg
// Shared types and codes of the single-wire bus master: item structs,
// configuration register indexes, line drive codes and the timer width.
// ---------------------------------------------------------------------------
package owm_pkg;

	localparam int TIMER_BITS  = 12;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	typedef logic [TIMER_BITS-1:0] timer_t;

	// command codes on the input channel
	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_RESET = 2'd1;
	localparam logic [1:0] FUNC_WRITE = 2'd2;
	localparam logic [1:0] FUNC_READ  = 2'd3;

	// line drive codes
	localparam logic [1:0] DRV_REL  = 2'd0;
	localparam logic [1:0] DRV_LOW  = 2'd1;
	localparam logic [1:0] DRV_HIGH = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_RESET_LOW  = 3'd0;
	localparam logic [2:0] REG_PRES_DELAY = 3'd1;
	localparam logic [2:0] REG_RECOVERY   = 3'd2;
	localparam logic [2:0] REG_SLOT_LOW   = 3'd3;
	localparam logic [2:0] REG_WR_HOLD    = 3'd4;
	localparam logic [2:0] REG_SAMPLE_DLY = 3'd5;
	localparam logic [2:0] REG_RD_TAIL    = 3'd6;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] data_byte;
		logic       line_level;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0] line_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_byte;
		logic       presence;
	} rsp_item_t;

	typedef struct packed {
		logic [11:0] reset_low_time;
		logic [11:0] presence_delay;
		logic [11:0] recovery_time;
		logic [7:0]  slot_low_time;
		logic [7:0]  write_hold_time;
		logic [7:0]  sample_delay;
		logic [7:0]  read_tail_time;
	} cfg_regs_t;

	typedef enum logic [1:0] {
		KIND_TICK,
		KIND_RESET,
		KIND_WRITE,
		KIND_READ
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
		logic       line_level;
	} q_item_t;

	typedef struct packed {
		logic    valid;
		q_item_t item;
	} q_head_t;

endpackage

// File: hdl/owm_cfg.sv
// ---------------------------------------------------------------------------
// owm_cfg
// Configuration register file: timing values written through the
// configuration channel, loaded with their defaults at reset.
// ---------------------------------------------------------------------------
module owm_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [11:0]        cfg_data,
	output owm_pkg::cfg_regs_t regs
);
	import owm_pkg::*;

	cfg_regs_t regs_q;

	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.reset_low_time  <= 12'd1250;
			regs_q.presence_delay  <= 12'd100;
			regs_q.recovery_time   <= 12'd1250;
			regs_q.slot_low_time   <= 8'd25;
			regs_q.write_hold_time <= 8'd120;
			regs_q.sample_delay    <= 8'd25;
			regs_q.read_tail_time  <= 8'd70;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_RESET_LOW:  regs_q.reset_low_time  <= cfg_data;
				REG_PRES_DELAY: regs_q.presence_delay  <= cfg_data;
				REG_RECOVERY:   regs_q.recovery_time   <= cfg_data;
				REG_SLOT_LOW:   regs_q.slot_low_time   <= cfg_data[7:0];
				REG_WR_HOLD:    regs_q.write_hold_time <= cfg_data[7:0];
				REG_SAMPLE_DLY: regs_q.sample_delay    <= cfg_data[7:0];
				REG_RD_TAIL:    regs_q.read_tail_time  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

endmodule

// File: hdl/owm_front.sv
// ---------------------------------------------------------------------------
// owm_front
// Front end: accepts items, classifies them by command and holds them in
// a short queue until the engine takes them.
// ---------------------------------------------------------------------------
module owm_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  owm_pkg::cmd_item_t cmd,
	output owm_pkg::q_head_t   head,
	input  logic               head_ready
);
	import owm_pkg::*;

	q_item_t              entries_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;
	q_item_t              cls;
	logic                 push;
	logic                 pop;

	always_comb begin
		cls.data_byte  = cmd.data_byte;
		cls.line_level = cmd.line_level;
		unique case (cmd.func)
			FUNC_TICK:  cls.kind = KIND_TICK;
			FUNC_RESET: cls.kind = KIND_RESET;
			FUNC_WRITE: cls.kind = KIND_WRITE;
			FUNC_READ:  cls.kind = KIND_READ;
			default:    cls.kind = KIND_TICK;
		endcase
	end

	assign cmd_ready  = (count_q != QCNT_BITS'(QUEUE_DEPTH));
	assign push       = cmd_valid && cmd_ready;
	assign head.valid = (count_q != '0);
	assign head.item  = entries_q[rd_ptr_q];
	assign pop        = head.valid && head_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + QPTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_BITS'(1);
			end
		end
	end

endmodule

// File: hdl/owm_engine.sv
// ---------------------------------------------------------------------------
// owm_engine
// Back end: bus phase sequencer with its timer, bit counter and shifter.
// Steps through one phase per cycle while a tick chains through expired
// phases, then registers the result item.
// ---------------------------------------------------------------------------
module owm_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  owm_pkg::cfg_regs_t regs,
	input  owm_pkg::q_head_t   head,
	output logic               head_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output owm_pkg::rsp_item_t rsp
);
	import owm_pkg::*;

	localparam logic [3:0] PH_IDLE      = 4'd0;
	localparam logic [3:0] PH_RST_LOW   = 4'd1;
	localparam logic [3:0] PH_RST_WAIT  = 4'd2;
	localparam logic [3:0] PH_RST_WATCH = 4'd3;
	localparam logic [3:0] PH_RST_RECOV = 4'd4;
	localparam logic [3:0] PH_WR_LOW    = 4'd5;
	localparam logic [3:0] PH_WR_HOLD   = 4'd6;
	localparam logic [3:0] PH_RD_LOW    = 4'd7;
	localparam logic [3:0] PH_RD_SAMPLE = 4'd8;
	localparam logic [3:0] PH_RD_TAIL   = 4'd9;

	logic [3:0] phase_q, phase_n;
	logic [2:0] bit_q, bit_n;
	timer_t     time_q, time_n, t_eff;
	logic [7:0] shift_q, shift_n;
	logic [7:0] accum_q, accum_n;
	logic       pres_q, pres_n;
	logic [1:0] drive_q, drive_n;
	logic       chain_q;
	logic       rsp_valid_q;
	rsp_item_t  rsp_q;
	logic       fin, cont, done_c, slot_free, commit;

	always_comb begin
		phase_n = phase_q;
		bit_n   = bit_q;
		time_n  = time_q;
		shift_n = shift_q;
		accum_n = accum_q;
		pres_n  = pres_q;
		drive_n = drive_q;
		t_eff   = time_q;
		fin     = 1'b0;
		cont    = 1'b0;
		done_c  = 1'b0;
		if (head.valid) begin
			if (head.item.kind == KIND_TICK) begin
				if (!chain_q && time_q != '0) begin
					t_eff = time_q - timer_t'(1);
				end
				time_n = t_eff;
				if (phase_q == PH_IDLE) begin
					fin = 1'b1;
				end else if (phase_q == PH_RST_WATCH) begin
					if (head.item.line_level) begin
						fin = 1'b1;
					end else begin
						pres_n  = 1'b1;
						phase_n = PH_RST_RECOV;
						time_n  = timer_t'(regs.recovery_time);
						cont    = 1'b1;
					end
				end else if (t_eff != '0) begin
					fin = 1'b1;
				end else begin
					cont = 1'b1;
					unique case (phase_q)
						PH_RST_LOW: begin
							drive_n = DRV_REL;
							phase_n = PH_RST_WAIT;
							time_n  = timer_t'(regs.presence_delay);
						end
						PH_RST_WAIT: begin
							phase_n = PH_RST_WATCH;
						end
						PH_RST_RECOV: begin
							phase_n = PH_IDLE;
							cont    = 1'b0;
							fin     = 1'b1;
							done_c  = 1'b1;
						end
						PH_WR_LOW: begin
							drive_n = shift_q[0] ? DRV_HIGH : DRV_LOW;
							shift_n = {1'b0, shift_q[7:1]};
							phase_n = PH_WR_HOLD;
							time_n  = timer_t'(regs.write_hold_time);
						end
						PH_WR_HOLD: begin
							if (bit_q == 3'd7) begin
								drive_n = DRV_REL;
								bit_n   = 3'd0;
								phase_n = PH_IDLE;
								cont    = 1'b0;
								fin     = 1'b1;
								done_c  = 1'b1;
							end else begin
								bit_n   = bit_q + 3'd1;
								drive_n = DRV_LOW;
								phase_n = PH_WR_LOW;
								time_n  = timer_t'(regs.slot_low_time);
							end
						end
						PH_RD_LOW: begin
							drive_n = DRV_REL;
							phase_n = PH_RD_SAMPLE;
							time_n  = timer_t'(regs.sample_delay);
						end
						PH_RD_SAMPLE: begin
							shift_n[bit_q] = shift_q[bit_q] | head.item.line_level;
							phase_n = PH_RD_TAIL;
							time_n  = timer_t'(regs.read_tail_time);
						end
						PH_RD_TAIL: begin
							if (bit_q == 3'd7) begin
								accum_n = shift_q;
								bit_n   = 3'd0;
								phase_n = PH_IDLE;
								cont    = 1'b0;
								fin     = 1'b1;
								done_c  = 1'b1;
							end else begin
								bit_n   = bit_q + 3'd1;
								drive_n = DRV_LOW;
								phase_n = PH_RD_LOW;
								time_n  = timer_t'(regs.slot_low_time);
							end
						end
						default: begin
							phase_n = PH_IDLE;
							drive_n = DRV_REL;
							cont    = 1'b0;
							fin     = 1'b1;
						end
					endcase
				end
			end else begin
				fin = 1'b1;
				if (phase_q == PH_IDLE) begin
					bit_n   = 3'd0;
					drive_n = DRV_LOW;
					unique case (head.item.kind)
						KIND_RESET: begin
							pres_n  = 1'b0;
							phase_n = PH_RST_LOW;
							time_n  = timer_t'(regs.reset_low_time);
						end
						KIND_WRITE: begin
							shift_n = head.item.data_byte;
							phase_n = PH_WR_LOW;
							time_n  = timer_t'(regs.slot_low_time);
						end
						default: begin
							shift_n = 8'd0;
							phase_n = PH_RD_LOW;
							time_n  = timer_t'(regs.slot_low_time);
						end
					endcase
				end
			end
		end
	end

	assign slot_free  = !rsp_valid_q || rsp_ready;
	assign head_ready = fin && slot_free;
	assign commit     = cont || head_ready;
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bit_q       <= 3'd0;
			time_q      <= '0;
			shift_q     <= 8'd0;
			accum_q     <= 8'd0;
			pres_q      <= 1'b0;
			drive_q     <= DRV_REL;
			chain_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				phase_q <= phase_n;
				bit_q   <= bit_n;
				time_q  <= time_n;
				shift_q <= shift_n;
				accum_q <= accum_n;
				pres_q  <= pres_n;
				drive_q <= drive_n;
				chain_q <= cont;
			end
			if (head_ready) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (head_ready) begin
			rsp_q.line_drive <= drive_n;
			rsp_q.busy_res   <= (phase_n != PH_IDLE);
			rsp_q.done_res   <= done_c;
			rsp_q.read_byte  <= accum_n;
			rsp_q.presence   <= pres_n;
		end
	end

endmodule

// File: hdl/one_wire_bus_master_unit.sv
// Timing: the result item is registered when the engine takes its item
// from the queue; a tick that runs through expired phases is taken only
// after its last phase step. Throughput: one item per cycle while the
// result channel is not stalled and no tick chains through expired
// phases, which the single-step phase sequencer runs through in turn.
// Reset: arst_n clears queue, sequencer and result valid flag at once; the
// timing registers return to their defaults.
// ---------------------------------------------------------------------------
// one_wire_bus_master_unit
// Single-wire bus master paced by microsecond ticks: reset with presence
// detect, byte write and byte read, LSB first.
// ---------------------------------------------------------------------------
module one_wire_bus_master_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  owm_pkg::cmd_item_t cmd,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output owm_pkg::rsp_item_t rsp,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [11:0]        cfg_data
);
	import owm_pkg::*;

	cfg_regs_t regs;
	q_head_t   head;
	logic      head_ready;

	owm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	owm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.head       (head),
		.head_ready (head_ready)
	);

	owm_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.regs       (regs),
		.head       (head),
		.head_ready (head_ready),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp)
	);

endmodule

// File: hdl/owm_checker.sv
// ---------------------------------------------------------------------------
// owm_port_checks
// Port-level checks on the result channel of the bus master, attached to
// the top level by bind.
// ---------------------------------------------------------------------------
module owm_port_checks (
	input logic               clk,
	input logic               arst_n,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input owm_pkg::rsp_item_t rsp
);
	import owm_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result item dropped or changed while stalled");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.done_res |-> !rsp.busy_res)
		else $error("completion reported while still busy");

	a_idle_released: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.busy_res |-> rsp.line_drive == DRV_REL)
		else $error("line still driven while idle");

	a_drive_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.line_drive == DRV_REL || rsp.line_drive == DRV_LOW
			|| rsp.line_drive == DRV_HIGH)
		else $error("undefined line drive code");

endmodule

bind one_wire_bus_master_unit owm_port_checks u_owm_port_checks (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
